// File: design/e2c_pkg.sv
// Shared types and constants for the epoch-to-calendar converter.
// Used by the channel interfaces, the month split and the top level.
// No dependencies.
`timescale 1ns / 1ps

package e2c_pkg;

   typedef logic [30:0] epoch_type;
   typedef logic [10:0] year_type;
   typedef logic [3:0]  month_type;
   typedef logic [4:0]  mday_type;
   typedef logic [4:0]  hour_type;
   typedef logic [5:0]  minute_type;
   typedef logic [5:0]  second_type;
   typedef logic [2:0]  weekday_type;
   typedef logic [8:0]  doy_type;

   // Calendar fields as they fill in along the pipeline.
   typedef struct packed {
      year_type    year;
      month_type   month;
      mday_type    day_of_month;
      hour_type    hour;
      minute_type  minute;
      second_type  second;
      weekday_type weekday;
   } cal_type;

   localparam int unsigned NUM_STAGES = 8;

   // 86400 = 128 * 675; the quotient by 675 uses a scaled reciprocal.
   localparam logic [16:0] SEC_PER_DAY   = 17'd86400;
   localparam logic [24:0] DAY_RECIP     = 25'd25451659;
   localparam int unsigned DAY_SHIFT     = 34;

   localparam logic [14:0] EPOCH_DAY_OFFSET = 15'd730;
   localparam logic [10:0] QUAD_DAYS     = 11'd1461;
   localparam logic [15:0] QUAD_RECIP    = 16'd45934;
   localparam int unsigned QUAD_SHIFT    = 26;
   localparam year_type    BASE_YEAR     = 11'd1968;

   localparam logic [10:0] YEAR1_START   = 11'd366;
   localparam logic [10:0] YEAR2_START   = 11'd731;
   localparam logic [10:0] YEAR3_START   = 11'd1096;

   // 3600 = 16 * 225.
   localparam logic [11:0] SEC_PER_HOUR  = 12'd3600;
   localparam logic [12:0] HOUR_RECIP    = 13'd4661;
   localparam int unsigned HOUR_SHIFT    = 20;

   // 60 = 4 * 15.
   localparam logic [5:0]  SEC_PER_MIN   = 6'd60;
   localparam logic [10:0] MIN_RECIP     = 11'd1093;
   localparam int unsigned MIN_SHIFT     = 14;

   localparam logic [14:0] WEEKDAY_BIAS  = 15'd3;

   // First day of each month in a common year, counted from zero.
   localparam doy_type MONTH_START [12] = '{
      9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
      9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
   };

endpackage

// File: design/e2c_req_if.sv
// Request channel of the epoch-to-calendar converter: valid, ready, epoch.
// Depends on e2c_pkg.
`timescale 1ns / 1ps

interface e2c_req_if;
   import e2c_pkg::*;

   logic      valid;
   logic      ready;
   epoch_type epoch_seconds;

   modport source (output valid, output epoch_seconds, input ready);
   modport sink   (input valid, input epoch_seconds, output ready);
endinterface

// File: design/e2c_rsp_if.sv
// Result channel of the epoch-to-calendar converter: valid, ready, date fields.
// Depends on e2c_pkg.
`timescale 1ns / 1ps

interface e2c_rsp_if;
   import e2c_pkg::*;

   logic        valid;
   logic        ready;
   year_type    year;
   month_type   month;
   mday_type    day_of_month;
   hour_type    hour;
   minute_type  minute;
   second_type  second;
   weekday_type weekday;

   modport source (output valid, output year, output month, output day_of_month,
                   output hour, output minute, output second, output weekday,
                   input ready);
   modport sink   (input valid, input year, input month, input day_of_month,
                   input hour, input minute, input second, input weekday,
                   output ready);
endinterface

// File: design/e2c_month_split.sv
// Splits a zero-based day of year into month and day of month.
// Depends on e2c_pkg for the month start table.
`timescale 1ns / 1ps

module e2c_month_split (
   input  e2c_pkg::doy_type   doy,
   input  logic               leap,
   output e2c_pkg::month_type month,
   output e2c_pkg::mday_type  day_of_month
);
   import e2c_pkg::*;

   doy_type start;
   doy_type base;
   doy_type offset;

   // Month starts are increasing, so the last start not above doy wins.
   always_comb begin
      month = 4'd1;
      base  = '0;
      for (int m = 0; m < 12; m++) begin
         start = MONTH_START[m] + ((leap && m >= 2) ? 9'd1 : 9'd0);
         if (doy >= start) begin
            month = 4'(m + 1);
            base  = start;
         end
      end
      offset       = doy - base;
      day_of_month = 5'(offset + 9'd1);
   end

endmodule

// File: design/epoch_to_calendar_unit.sv
// Epoch-to-calendar converter: seconds since 1969-12-31 to date, time and weekday.
// Throughput: one request per cycle while results are taken; eight pipeline stages each with its own
// valid bit, so bubbles close up and a held result stalls only the full stages behind it.
// Reset clears all stage valid bits; the data path registers are not reset.
// Depends on e2c_pkg, e2c_req_if, e2c_rsp_if and e2c_month_split.
`timescale 1ns / 1ps

module epoch_to_calendar_unit (
   input logic       clock,
   input logic       reset,
   e2c_req_if.sink   req_chan,
   e2c_rsp_if.source rsp_chan
);
   import e2c_pkg::*;

   logic [NUM_STAGES-1:0] v_ff;
   logic [NUM_STAGES-1:0] v_in;
   logic [NUM_STAGES-1:0] adv;

   // A stage loads when it is empty or its contents move on.
   always_comb begin
      adv[NUM_STAGES-1] = !v_ff[NUM_STAGES-1] || rsp_chan.ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         adv[k] = !v_ff[k] || adv[k+1];
      end
      v_in[0] = req_chan.valid;
      for (int k = 1; k < NUM_STAGES; k++) begin
         v_in[k] = v_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < NUM_STAGES; k++) begin
            if (adv[k]) begin
               v_ff[k] <= v_in[k];
            end
         end
      end
   end

   assign req_chan.ready = adv[0];

   // Stage 0: input register.
   epoch_type s0_ff;

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s0_ff <= req_chan.epoch_seconds;
      end
   end

   // Stage 1: day count by reciprocal multiply.
   logic [48:0] day_prod;
   logic [14:0] days1_in, days1_ff;
   epoch_type   s1_ff;

   assign day_prod = 49'(s0_ff[30:7]) * 49'(DAY_RECIP);
   assign days1_in = day_prod[DAY_SHIFT +: 15];

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         days1_ff <= days1_in;
         s1_ff    <= s0_ff;
      end
   end

   // Stage 2: seconds in whole days, four-year block number, weekday.
   logic [31:0] day_secs;
   logic [14:0] dnum2_in, dnum2_ff;
   logic [30:0] quad_prod;
   logic [4:0]  quad2_in, quad2_ff;
   logic [30:0] day_secs2_ff;
   epoch_type   s2_ff;
   logic [14:0] wd_sum;
   logic [5:0]  wd_fold1;
   logic [3:0]  wd_fold2;
   cal_type     cal2_in, cal2_ff;

   assign day_secs  = 32'(days1_ff) * 32'(SEC_PER_DAY);
   assign dnum2_in  = days1_ff + EPOCH_DAY_OFFSET;
   assign quad_prod = 31'(dnum2_in) * 31'(QUAD_RECIP);
   assign quad2_in  = quad_prod[QUAD_SHIFT +: 5];

   // Eight is one modulo seven, so octal digits are summed and then folded.
   always_comb begin
      wd_sum   = days1_ff + WEEKDAY_BIAS;
      wd_fold1 = 6'(wd_sum[2:0]) + 6'(wd_sum[5:3]) + 6'(wd_sum[8:6])
               + 6'(wd_sum[11:9]) + 6'(wd_sum[14:12]);
      wd_fold2 = 4'(wd_fold1[2:0]) + 4'(wd_fold1[5:3]);
      cal2_in  = '0;
      cal2_in.weekday = (wd_fold2 >= 4'd7) ? 3'(wd_fold2 - 4'd7) : wd_fold2[2:0];
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         day_secs2_ff <= day_secs[30:0];
         dnum2_ff     <= dnum2_in;
         quad2_ff     <= quad2_in;
         s2_ff        <= s1_ff;
         cal2_ff      <= cal2_in;
      end
   end

   // Stage 3: time of day and day within the four-year block.
   logic [30:0] tod_full;
   logic [16:0] tod3_ff;
   logic [14:0] quad_days;
   logic [14:0] r_full;
   logic [10:0] r3_ff;
   logic [4:0]  quad3_ff;
   cal_type     cal3_ff;

   assign tod_full  = s2_ff - day_secs2_ff;
   assign quad_days = 15'(quad2_ff) * 15'(QUAD_DAYS);
   assign r_full    = dnum2_ff - quad_days;

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         tod3_ff  <= tod_full[16:0];
         r3_ff    <= r_full[10:0];
         quad3_ff <= quad2_ff;
         cal3_ff  <= cal2_ff;
      end
   end

   // Stage 4: hour by reciprocal multiply; year and day of year.
   logic [25:0] hour_prod;
   logic [1:0]  yoff;
   logic [10:0] doy_full;
   logic        leap4_in, leap4_ff;
   doy_type     doy4_ff;
   logic [16:0] tod4_ff;
   cal_type     cal4_in, cal4_ff;

   assign hour_prod = 26'(tod3_ff[16:4]) * 26'(HOUR_RECIP);

   // The first year of each four-year block is the leap year.
   always_comb begin
      if (r3_ff < YEAR1_START) begin
         yoff = 2'd0; doy_full = r3_ff;
      end else if (r3_ff < YEAR2_START) begin
         yoff = 2'd1; doy_full = r3_ff - YEAR1_START;
      end else if (r3_ff < YEAR3_START) begin
         yoff = 2'd2; doy_full = r3_ff - YEAR2_START;
      end else begin
         yoff = 2'd3; doy_full = r3_ff - YEAR3_START;
      end
      leap4_in     = (yoff == 2'd0);
      cal4_in      = cal3_ff;
      cal4_in.hour = hour_prod[HOUR_SHIFT +: 5];
      cal4_in.year = BASE_YEAR + {4'd0, quad3_ff, 2'd0} + 11'(yoff);
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         doy4_ff  <= doy_full[8:0];
         leap4_ff <= leap4_in;
         tod4_ff  <= tod3_ff;
         cal4_ff  <= cal4_in;
      end
   end

   // Stage 5: seconds within the hour; month and day of month.
   logic [16:0] hour_secs;
   logic [16:0] rem_full;
   logic [11:0] rem5_ff;
   month_type   month5;
   mday_type    mday5;
   cal_type     cal5_in, cal5_ff;

   assign hour_secs = 17'(cal4_ff.hour) * 17'(SEC_PER_HOUR);
   assign rem_full  = tod4_ff - hour_secs;

   e2c_month_split u_month_split (
      .doy          (doy4_ff),
      .leap         (leap4_ff),
      .month        (month5),
      .day_of_month (mday5)
   );

   always_comb begin
      cal5_in              = cal4_ff;
      cal5_in.month        = month5;
      cal5_in.day_of_month = mday5;
   end

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         rem5_ff <= rem_full[11:0];
         cal5_ff <= cal5_in;
      end
   end

   // Stage 6: minute by reciprocal multiply.
   logic [20:0] min_prod;
   logic [11:0] rem6_ff;
   cal_type     cal6_in, cal6_ff;

   assign min_prod = 21'(rem5_ff[11:2]) * 21'(MIN_RECIP);

   always_comb begin
      cal6_in        = cal5_ff;
      cal6_in.minute = min_prod[MIN_SHIFT +: 6];
   end

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         rem6_ff <= rem5_ff;
         cal6_ff <= cal6_in;
      end
   end

   // Stage 7: second, then the result register.
   logic [11:0] min_secs;
   logic [11:0] sec_full;
   cal_type     cal7_in, cal7_ff;

   assign min_secs = 12'(cal6_ff.minute) * 12'(SEC_PER_MIN);
   assign sec_full = rem6_ff - min_secs;

   always_comb begin
      cal7_in        = cal6_ff;
      cal7_in.second = sec_full[5:0];
   end

   always_ff @(posedge clock) begin
      if (adv[7]) begin
         cal7_ff <= cal7_in;
      end
   end

   assign rsp_chan.valid        = v_ff[NUM_STAGES-1];
   assign rsp_chan.year         = cal7_ff.year;
   assign rsp_chan.month        = cal7_ff.month;
   assign rsp_chan.day_of_month = cal7_ff.day_of_month;
   assign rsp_chan.hour         = cal7_ff.hour;
   assign rsp_chan.minute       = cal7_ff.minute;
   assign rsp_chan.second       = cal7_ff.second;
   assign rsp_chan.weekday      = cal7_ff.weekday;

   a_accept_fills_stage0: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> v_ff[0])
      else $error("accepted request did not enter the first stage");

   a_tod_range: assert property (@(posedge clock) disable iff (reset)
      v_ff[3] |-> tod3_ff < SEC_PER_DAY)
      else $error("time of day out of range");

   a_date_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.month >= 4'd1 && rsp_chan.month <= 4'd12
                      && rsp_chan.day_of_month >= 5'd1)
      else $error("month or day of month out of range");

   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.hour <= 5'd23 && rsp_chan.minute <= 6'd59
                      && rsp_chan.second <= 6'd59 && rsp_chan.weekday <= 3'd6)
      else $error("time or weekday out of range");

   a_leap_day: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.month == 4'd2 && rsp_chan.day_of_month > 5'd28
      |-> rsp_chan.year[1:0] == 2'd0 && rsp_chan.day_of_month == 5'd29)
      else $error("February day beyond the leap day");

endmodule
